[rtl/core/rsrg_pkg.sv]
// Package: shared constants, types and tables for the rosette scan ray generator.
package rsrg_pkg;

  localparam int unsigned IndexBits    = 24;
  localparam int unsigned CordicStages = 16;
  localparam int unsigned NumRegs      = 8;
  localparam int unsigned RegIdxBits   = 3;

  // CORDIC datapath width: Q2.30 plus guard bits
  localparam int unsigned CW = 34;
  localparam logic signed [CW-1:0] CordicGain = 34'sh026DD3B6A;

  typedef enum logic [RegIdxBits-1:0] {
    REG_STEP_FAST = 3'd0,
    REG_STEP_SLOW = 3'd1,
    REG_AMPLITUDE = 3'd2,
    REG_DEPTH     = 3'd3,
    REG_ORIENT    = 3'd4,
    REG_ORIGIN_X  = 3'd5,
    REG_ORIGIN_Y  = 3'd6,
    REG_ORIGIN_Z  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [31:0]        step_fast;
    logic [31:0]        step_slow;
    logic signed [31:0] amplitude;
    logic signed [31:0] depth;
    logic [31:0]        orient;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
  } cfg_t;

  // register values after reset: depth one, all else zero
  localparam cfg_t CfgReset = '{
    step_fast: 32'h0,
    step_slow: 32'h0,
    amplitude: 32'sh0,
    depth:     32'sd65536,
    orient:    32'h0,
    origin_x:  32'sh0,
    origin_y:  32'sh0,
    origin_z:  32'sh0
  };

  // pipeline stall control from top to stages
  typedef struct packed {
    logic adv;
  } pipe_ctrl_t;

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic signed [CW-1:0] atan_turns(input int unsigned i);
    logic [31:0] t;
    unique case (i)
      0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      default: t = 32'h0;
    endcase
    return signed'({2'b00, t});
  endfunction

  // round a Q16.16 x Q2.30 product sum and wrap to 32 bits
  function automatic logic signed [31:0] rnd30(input logic signed [67:0] p);
    logic signed [67:0] r;
    r = (p + 68'sd536870912) >>> 30;
    return r[31:0];
  endfunction

endpackage

[rtl/core/rosette_scan_ray_generator_top.sv]
// Top level: config registers, phase multiply, CORDICs, rotation and output register.
// Rosette scan ray generator: each word on the input carries a sample index and yields
// one world-frame ray point word. Fully pipelined: one word per cycle sustained, through
// the phase multiply, CORDIC load and iteration stages, seven rotation stages and the
// output register. Words stall in place when the output is not taken. Configuration
// must be written while the pipeline is empty.
module rosette_scan_ray_generator_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rsrg_pkg::RegIdxBits-1:0]  cfg_idx_i,
  input  logic [31:0]                      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rsrg_pkg::IndexBits-1:0]   sample_index_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [31:0]               point_x_o,
  output logic signed [31:0]               point_y_o,
  output logic signed [31:0]               point_z_o
);
  // top index of the valid chain: phase, CORDIC load and stages, rotation
  localparam int unsigned Depth = rsrg_pkg::CordicStages + 8;

  rsrg_pkg::cfg_t cfg_q;
  rsrg_pkg::pipe_ctrl_t ctrl;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= rsrg_pkg::CfgReset;
    end else if (cfg_we_i) begin
      unique case (rsrg_pkg::reg_idx_e'(cfg_idx_i))
        rsrg_pkg::REG_STEP_FAST: cfg_q.step_fast <= cfg_data_i;
        rsrg_pkg::REG_STEP_SLOW: cfg_q.step_slow <= cfg_data_i;
        rsrg_pkg::REG_AMPLITUDE: cfg_q.amplitude <= cfg_data_i;
        rsrg_pkg::REG_DEPTH:     cfg_q.depth     <= cfg_data_i;
        rsrg_pkg::REG_ORIENT:    cfg_q.orient    <= cfg_data_i;
        rsrg_pkg::REG_ORIGIN_X:  cfg_q.origin_x  <= cfg_data_i;
        rsrg_pkg::REG_ORIGIN_Y:  cfg_q.origin_y  <= cfg_data_i;
        default:                 cfg_q.origin_z  <= cfg_data_i;
      endcase
    end
  end

  // valid chain; whole pipe advances unless output is full and stalled
  logic [Depth:0] vld_q;
  logic           out_vld_q;
  assign ctrl.adv   = !out_vld_q || out_ready_i;
  assign in_ready_o = ctrl.adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (ctrl.adv) begin
      vld_q     <= {vld_q[Depth-1:0], in_valid_i};
      out_vld_q <= vld_q[Depth];
    end
  end

  // phase multiply stage
  logic [31:0] p1_q, p2_q;
  logic [31:0] n32;
  assign n32 = 32'(sample_index_i);
  always_ff @(posedge clk_i) begin
    if (ctrl.adv) begin
      p1_q <= 32'(n32 * cfg_q.step_fast);
      p2_q <= 32'(n32 * cfg_q.step_slow);
    end
  end

  // negated orientation angles
  logic [31:0] roll_ang, pitch_ang;
  assign roll_ang  = {16'(17'h10000 - {1'b0, cfg_q.orient[15:0]}), 16'h0};
  assign pitch_ang = {16'(17'h10000 - {1'b0, cfg_q.orient[31:16]}), 16'h0};

  logic signed [rsrg_pkg::CW-1:0] c1, s1, c2, s2, cr, sr, cp, sp;
  rsrg_cordic u_cor1 (.clk_i, .ctrl_i(ctrl), .angle_i(p1_q), .cos_o(c1), .sin_o(s1));
  rsrg_cordic u_cor2 (.clk_i, .ctrl_i(ctrl), .angle_i(p2_q), .cos_o(c2), .sin_o(s2));
  rsrg_cordic u_corr (.clk_i, .ctrl_i(ctrl), .angle_i(roll_ang),
                      .cos_o(cr), .sin_o(sr));
  rsrg_cordic u_corp (.clk_i, .ctrl_i(ctrl), .angle_i(pitch_ang),
                      .cos_o(cp), .sin_o(sp));

  logic signed [31:0] wx, wy, wz;
  rsrg_rotate u_rot (
    .clk_i, .ctrl_i(ctrl), .cfg_i(cfg_q),
    .c1_i(c1), .s1_i(s1), .c2_i(c2), .s2_i(s2),
    .cr_i(cr), .sr_i(sr), .cp_i(cp), .sp_i(sp),
    .x_o(wx), .y_o(wy), .z_o(wz)
  );

  // output register
  always_ff @(posedge clk_i) begin
    if (ctrl.adv) begin
      point_x_o <= wx;
      point_y_o <= wy;
      point_z_o <= wz;
    end
  end
  assign out_valid_o = out_vld_q;

  // a stalled output word holds its valid
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |=> out_vld_q) else $error("output word dropped");
  // pipe never stalls while the output register is empty
  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_ready_o) else $error("stall with empty output");
  // accepted word shows up in the valid chain
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0]) else $error("word lost at entry");
endmodule

[rtl/core/rsrg_cordic.sv]
// Pipelined rotation-mode CORDIC, one stage per register, angle in turns.
module rsrg_cordic (
  input  logic                                   clk_i,
  input  rsrg_pkg::pipe_ctrl_t                   ctrl_i,
  input  logic [31:0]                            angle_i,
  output logic signed [rsrg_pkg::CW-1:0]         cos_o,
  output logic signed [rsrg_pkg::CW-1:0]         sin_o
);
  localparam int unsigned N  = rsrg_pkg::CordicStages;
  localparam int unsigned CW = rsrg_pkg::CW;

  logic signed [CW-1:0] x_q [N+1];
  logic signed [CW-1:0] y_q [N+1];
  logic signed [CW-1:0] z_q [N+1];
  logic [1:0]           quad_q [N+1];

  // stage 0 load
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      x_q[0]    <= rsrg_pkg::CordicGain;
      y_q[0]    <= '0;
      z_q[0]    <= signed'({4'b0000, angle_i[29:0]});
      quad_q[0] <= angle_i[31:30];
    end
  end

  // iteration stages
  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (ctrl_i.adv) begin
        if (!z_q[i][CW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - rsrg_pkg::atan_turns(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + rsrg_pkg::atan_turns(i);
        end
        quad_q[i+1] <= quad_q[i];
      end
    end
  end

  // quadrant fold
  always_comb begin
    unique case (quad_q[N])
      2'd0:    begin cos_o = x_q[N];  sin_o = y_q[N];  end
      2'd1:    begin cos_o = -y_q[N]; sin_o = x_q[N];  end
      2'd2:    begin cos_o = -x_q[N]; sin_o = -y_q[N]; end
      default: begin cos_o = y_q[N];  sin_o = -x_q[N]; end
    endcase
  end
endmodule

[rtl/core/rsrg_rotate.sv]
// Pattern scaling, roll and pitch rotation and origin add, registered stages.
module rsrg_rotate (
  input  logic                           clk_i,
  input  rsrg_pkg::pipe_ctrl_t           ctrl_i,
  input  rsrg_pkg::cfg_t                 cfg_i,
  input  logic signed [rsrg_pkg::CW-1:0] c1_i, s1_i, c2_i, s2_i,
  input  logic signed [rsrg_pkg::CW-1:0] cr_i, sr_i, cp_i, sp_i,
  output logic signed [31:0]             x_o,
  output logic signed [31:0]             y_o,
  output logic signed [31:0]             z_o
);
  localparam int unsigned CW = rsrg_pkg::CW;

  // stage A: sums
  logic signed [CW:0] csum_q, ssum_q;
  logic signed [CW-1:0] cra_q, sra_q, cpa_q, spa_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      csum_q <= {c1_i[CW-1], c1_i} + {c2_i[CW-1], c2_i};
      ssum_q <= {s1_i[CW-1], s1_i} + {s2_i[CW-1], s2_i};
      cra_q <= cr_i; sra_q <= sr_i; cpa_q <= cp_i; spa_q <= sp_i;
    end
  end

  // stage B: scale by amplitude
  logic signed [67:0] px_q, py_q;
  logic signed [CW-1:0] crb_q, srb_q, cpb_q, spb_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      px_q <= 68'(cfg_i.amplitude * csum_q);
      py_q <= 68'(cfg_i.amplitude * ssum_q);
      crb_q <= cra_q; srb_q <= sra_q; cpb_q <= cpa_q; spb_q <= spa_q;
    end
  end

  // stage C: round sensor frame
  logic signed [31:0] xs_q, ys_q;
  logic signed [CW-1:0] crc_q, src_q, cpc_q, spc_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      xs_q <= rsrg_pkg::rnd30(px_q);
      ys_q <= rsrg_pkg::rnd30(py_q);
      crc_q <= crb_q; src_q <= srb_q; cpc_q <= cpb_q; spc_q <= spb_q;
    end
  end

  // stage D: roll products
  logic signed [67:0] r1_q, r2_q, r3_q, r4_q;
  logic signed [31:0] xd_q;
  logic signed [CW-1:0] cpd_q, spd_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      r1_q <= 68'(crc_q * ys_q);
      r2_q <= 68'(src_q * cfg_i.depth);
      r3_q <= 68'(src_q * ys_q);
      r4_q <= 68'(crc_q * cfg_i.depth);
      xd_q <= xs_q; cpd_q <= cpc_q; spd_q <= spc_q;
    end
  end

  // stage E: roll round
  logic signed [31:0] y1_q, z1_q, xe_q;
  logic signed [CW-1:0] cpe_q, spe_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      y1_q <= rsrg_pkg::rnd30(r1_q - r2_q);
      z1_q <= rsrg_pkg::rnd30(r3_q + r4_q);
      xe_q <= xd_q; cpe_q <= cpd_q; spe_q <= spd_q;
    end
  end

  // stage F: pitch products
  logic signed [67:0] q1_q, q2_q, q3_q, q4_q;
  logic signed [31:0] y1f_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      q1_q <= 68'(cpe_q * xe_q);
      q2_q <= 68'(spe_q * z1_q);
      q3_q <= 68'(cpe_q * z1_q);
      q4_q <= 68'(spe_q * xe_q);
      y1f_q <= y1_q;
    end
  end

  // stage G: pitch round
  logic signed [31:0] x2_q, z2_q, y2_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      x2_q <= rsrg_pkg::rnd30(q1_q + q2_q);
      z2_q <= rsrg_pkg::rnd30(q3_q - q4_q);
      y2_q <= y1f_q;
    end
  end

  // origin add
  assign x_o = x2_q + cfg_i.origin_x;
  assign y_o = y2_q + cfg_i.origin_y;
  assign z_o = z2_q + cfg_i.origin_z;
endmodule

[verif/rosette_scan_ray_generator_top_tb.sv]
// Testbench for the rosette scan ray generator: bit-exact ray point prediction and checking.
module rosette_scan_ray_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } ray_point_t;

  // atan(2^-i) in 2^32-per-turn units
  localparam longint AtanTab [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [rsrg_pkg::RegIdxBits-1:0] cfg_idx_i = '0;
  logic [31:0]                     cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic [rsrg_pkg::IndexBits-1:0]  sample_index_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic signed [31:0]              point_x_o, point_y_o, point_z_o;

  // register shadow and expected ray points
  logic [31:0] reg_shadow [rsrg_pkg::NumRegs];
  ray_point_t  pending_points [$];
  int          fail_cnt = 0;
  bit          no_idle = 1'b0;

  // values sampled mid-cycle; inputs only move at the rising edge
  logic in_rdy_s, out_vld_s, out_rdy_s;
  logic signed [31:0] px_s, py_s, pz_s;

  rosette_scan_ray_generator_top dut (.*);

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    in_rdy_s  = in_ready_o;
    out_vld_s = out_valid_o;
    out_rdy_s = out_ready_i;
    px_s = point_x_o;
    py_s = point_y_o;
    pz_s = point_z_o;
  end

  // rotation-mode CORDIC, angle in turns
  function automatic void sin_cos(input logic [31:0] ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = 64'h26DD3B6A;
    y = 0;
    z = longint'(ang[29:0]);
    for (int i = 0; i < rsrg_pkg::CordicStages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTab[i];
      end else begin
        x += dx; y -= dy; z += AtanTab[i];
      end
    end
    case (ang[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint round_q30(input longint p);
    longint r;
    logic signed [31:0] w;
    r = (p + (64'sd1 <<< 29)) >>> 30;
    w = r[31:0];
    return longint'(w);
  endfunction

  function automatic longint sx(input logic [31:0] v);
    logic signed [31:0] t;
    t = v;
    return longint'(t);
  endfunction

  function automatic ray_point_t predict_point(input logic [rsrg_pkg::IndexBits-1:0] n);
    logic [31:0] p1, p2, roll_ang, pitch_ang;
    logic [15:0] roll, pitch;
    longint c1, s1, c2, s2, cr, sr, cp, sp, amp, x, y, z, y1, z1, x2, z2;
    ray_point_t r;
    p1 = 32'(64'(n) * reg_shadow[rsrg_pkg::REG_STEP_FAST]);
    p2 = 32'(64'(n) * reg_shadow[rsrg_pkg::REG_STEP_SLOW]);
    roll  = reg_shadow[rsrg_pkg::REG_ORIENT][15:0];
    pitch = reg_shadow[rsrg_pkg::REG_ORIENT][31:16];
    roll_ang  = {16'(-roll), 16'h0};
    pitch_ang = {16'(-pitch), 16'h0};
    sin_cos(p1, c1, s1);
    sin_cos(p2, c2, s2);
    sin_cos(roll_ang, cr, sr);
    sin_cos(pitch_ang, cp, sp);
    amp = sx(reg_shadow[rsrg_pkg::REG_AMPLITUDE]);
    x = round_q30(amp * (c1 + c2));
    y = round_q30(amp * (s1 + s2));
    z = sx(reg_shadow[rsrg_pkg::REG_DEPTH]);
    y1 = round_q30(cr * y - sr * z);
    z1 = round_q30(sr * y + cr * z);
    x2 = round_q30(cp * x + sp * z1);
    z2 = round_q30(cp * z1 - sp * x);
    r.x = 32'(x2 + sx(reg_shadow[rsrg_pkg::REG_ORIGIN_X]));
    r.y = 32'(y1 + sx(reg_shadow[rsrg_pkg::REG_ORIGIN_Y]));
    r.z = 32'(z2 + sx(reg_shadow[rsrg_pkg::REG_ORIGIN_Z]));
    return r;
  endfunction

  // send one sample index word and queue its expected point
  task automatic send_index(input logic [rsrg_pkg::IndexBits-1:0] n);
    int gap;
    gap = no_idle ? 0 : $urandom_range(3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_index_i <= n;
    do @(posedge clk_i); while (!in_rdy_s);
    pending_points.push_back(predict_point(n));
  endtask

  // register write; only while the pipeline is empty
  task automatic write_reg(input rsrg_pkg::reg_idx_e idx, input logic [31:0] val);
    in_valid_i <= 1'b0;
    wait (pending_points.size() == 0);
    repeat (rsrg_pkg::CordicStages + 14) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reg_shadow[idx] = val;
  endtask

  task automatic write_all(input logic [31:0] v [rsrg_pkg::NumRegs]);
    for (int i = 0; i < rsrg_pkg::NumRegs; i++) write_reg(rsrg_pkg::reg_idx_e'(i), v[i]);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // receiver: random stalls per word
  initial begin
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(3);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_vld_s);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    ray_point_t e;
    if (out_vld_s && out_rdy_s) begin
      if (pending_points.size() == 0) begin
        $error("unexpected point word x=%0d y=%0d z=%0d", px_s, py_s, pz_s);
        fail_cnt++;
      end else begin
        e = pending_points.pop_front();
        if (px_s !== e.x) begin
          $error("point_x expected %0d actual %0d", e.x, px_s); fail_cnt++;
        end
        if (py_s !== e.y) begin
          $error("point_y expected %0d actual %0d", e.y, py_s); fail_cnt++;
        end
        if (pz_s !== e.z) begin
          $error("point_z expected %0d actual %0d", e.z, pz_s); fail_cnt++;
        end
      end
    end
  end

  // reset values: amplitude zero, depth one
  task automatic test_reset_defaults();
    send_index('0);
    send_index(24'hFFFFFF);
    send_index(24'h123456);
  endtask

  // field extremes and typical rosette settings
  task automatic test_directed();
    logic [31:0] v [rsrg_pkg::NumRegs];
    v = '{32'h0123_4567, 32'hFEDC_BA98, 32'h0001_8000, 32'h0010_0000,
          32'h2000_4000, 32'h0003_0000, 32'hFFFD_0000, 32'h0000_8000};
    write_all(v);
    foreach (v[i]) send_index(24'(1 << i));
    send_index('0);
    send_index(24'hFFFFFF);
    send_index(24'hAAAAAA);
    send_index(24'h555555);
    // extreme amplitude and depth wrap the intermediates
    v = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    write_all(v);
    send_index(24'd1);
    send_index(24'hFFFFFF);
    send_index(24'h800000);
    v = '{32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h8000_8000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
    write_all(v);
    send_index(24'd3);
    send_index(24'h7FFFFF);
  endtask

  // random configurations, random indices; one phase without any idling
  task automatic test_random_phases();
    logic [31:0] v [rsrg_pkg::NumRegs];
    for (int ph = 0; ph < 6; ph++) begin
      foreach (v[i]) v[i] = pick_value();
      write_all(v);
      no_idle = (ph == 2);
      for (int k = 0; k < 255; k++)
        send_index($urandom_range(3) == 0 ? 24'($urandom_range(255)) : 24'($urandom));
      no_idle = 1'b0;
    end
  endtask

  initial begin
    for (int i = 0; i < rsrg_pkg::NumRegs; i++) reg_shadow[i] = '0;
    reg_shadow[rsrg_pkg::REG_DEPTH] = 32'h0001_0000;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_random_phases();
    in_valid_i <= 1'b0;
    wait (pending_points.size() == 0);
    repeat (rsrg_pkg::CordicStages + 14) @(posedge clk_i);
    if (fail_cnt == 0) $display("rosette_scan_ray_generator_top_tb OK");
    else $display("rosette_scan_ray_generator_top_tb NOT OK");
    $finish;
  end

  initial begin
    #5ms;
    $display("rosette_scan_ray_generator_top_tb NOT OK");
    $finish;
  end

endmodule

[rosette_scan_ray_generator_top.f]
rtl/core/rsrg_pkg.sv
rtl/core/rsrg_cordic.sv
rtl/core/rsrg_rotate.sv
rtl/core/rosette_scan_ray_generator_top.sv
verif/rosette_scan_ray_generator_top_tb.sv
